// ----- sv/jse_pkg.sv -----
// Package with the types, byte constants and helper functions of the JSON string escaper.
package jse_pkg;

	// Bytes that the escaper emits or tests for.
	localparam logic [7:0] QUOTE     = 8'h22;
	localparam logic [7:0] BSLASH    = 8'h5C;
	localparam logic [7:0] LF        = 8'h0A;
	localparam logic [7:0] CR        = 8'h0D;
	localparam logic [7:0] TAB       = 8'h09;
	localparam logic [7:0] CHAR_N    = 8'h6E;
	localparam logic [7:0] CHAR_R    = 8'h72;
	localparam logic [7:0] CHAR_T    = 8'h74;
	localparam logic [7:0] CHAR_U    = 8'h75;
	localparam logic [7:0] CHAR_0    = 8'h30;
	localparam logic [7:0] HEX_ALPHA = 8'h57;
	localparam logic [7:0] CTRL_TOP  = 8'h20;
	localparam logic [7:0] ASCII_TOP = 8'h80;

	// UTF-8 lead and continuation bounds.
	localparam logic [7:0] LEAD2_LO  = 8'hC2;
	localparam logic [7:0] LEAD2_HI  = 8'hDF;
	localparam logic [7:0] LEAD3_LO  = 8'hE0;
	localparam logic [7:0] LEAD3_HI  = 8'hEF;
	localparam logic [7:0] LEAD4_LO  = 8'hF0;
	localparam logic [7:0] LEAD4_HI  = 8'hF4;
	localparam logic [7:0] LEAD_SURR = 8'hED;
	localparam logic [7:0] CONT_LO   = 8'h80;
	localparam logic [7:0] CONT_HI   = 8'hBF;
	localparam logic [7:0] E0_LO     = 8'hA0;
	localparam logic [7:0] ED_HI     = 8'h9F;
	localparam logic [7:0] F0_LO     = 8'h90;
	localparam logic [7:0] F4_HI     = 8'h8F;

	// U+FFFD in UTF-8, first byte in the low position.
	localparam logic [23:0] REPL = 24'hBDBFEF;

	// Output bytes of one fresh byte, first byte in the low position.
	typedef struct packed {
		logic [47:0] seg;
		logic [2:0]  len;
		logic        hold;
	} fresh_t;

	// Total sequence length for a valid lead byte, zero otherwise.
	function automatic logic [2:0] seq_len(input logic [7:0] lead);
		logic [2:0] n;
		n = 3'd0;
		if (lead >= LEAD2_LO && lead <= LEAD2_HI) n = 3'd2;
		if (lead >= LEAD3_LO && lead <= LEAD3_HI) n = 3'd3;
		if (lead >= LEAD4_LO && lead <= LEAD4_HI) n = 3'd4;
		return n;
	endfunction

	// Whether b may follow the held lead at the given position.
	function automatic logic cont_ok(input logic [1:0] pos, input logic [7:0] lead,
			input logic [7:0] b);
		logic [7:0] lo;
		logic [7:0] hi;
		lo = CONT_LO;
		hi = CONT_HI;
		if (pos == 2'd1) begin
			if (lead == LEAD3_LO) lo = E0_LO;
			if (lead == LEAD_SURR) hi = ED_HI;
			if (lead == LEAD4_LO) lo = F0_LO;
			if (lead == LEAD4_HI) hi = F4_HI;
		end
		return (b >= lo) && (b <= hi);
	endfunction

	// Lowercase hex digit.
	function automatic logic [7:0] hex_digit(input logic [3:0] n);
		logic [7:0] d;
		if (n < 4'd10) d = CHAR_0 + {4'h0, n};
		else d = HEX_ALPHA + {4'h0, n};
		return d;
	endfunction

	// A run of k replacement characters, first byte in the low position.
	function automatic logic [71:0] repl_run(input logic [1:0] k);
		logic [71:0] r;
		case (k)
			2'd1:    r = {48'h0, REPL};
			2'd2:    r = {24'h0, REPL, REPL};
			2'd3:    r = {REPL, REPL, REPL};
			default: r = '0;
		endcase
		return r;
	endfunction

	// Byte count of a run of k replacement characters.
	function automatic logic [3:0] repl_len(input logic [1:0] k);
		return {1'b0, k, 1'b0} + {2'b00, k};
	endfunction

	// Handling of a byte that does not continue a held sequence.
	function automatic fresh_t fresh(input logic [7:0] c);
		fresh_t f;
		f.seg  = '0;
		f.len  = 3'd0;
		f.hold = 1'b0;
		case (c)
			QUOTE: begin
				f.seg = {32'h0, QUOTE, BSLASH};
				f.len = 3'd2;
			end
			BSLASH: begin
				f.seg = {32'h0, BSLASH, BSLASH};
				f.len = 3'd2;
			end
			LF: begin
				f.seg = {32'h0, CHAR_N, BSLASH};
				f.len = 3'd2;
			end
			CR: begin
				f.seg = {32'h0, CHAR_R, BSLASH};
				f.len = 3'd2;
			end
			TAB: begin
				f.seg = {32'h0, CHAR_T, BSLASH};
				f.len = 3'd2;
			end
			default: begin
				if (c < CTRL_TOP) begin
					f.seg = {hex_digit(c[3:0]), hex_digit(c[7:4]), CHAR_0, CHAR_0,
						CHAR_U, BSLASH};
					f.len = 3'd6;
				end else if (c < ASCII_TOP) begin
					f.seg = {40'h0, c};
					f.len = 3'd1;
				end else if (seq_len(c) != 3'd0) begin
					f.hold = 1'b1;
				end else begin
					f.seg = {24'h0, REPL};
					f.len = 3'd3;
				end
			end
		endcase
		return f;
	endfunction

endpackage

// ----- sv/json_string_escape_utf8.sv -----
// Top level of the streaming JSON string escaper with UTF-8 validation.

// One string byte is taken per request into an input register; from there the whole
// escaped run for that byte (opening quote, replacement characters, escape or UTF-8
// sequence, closing quote, at most 16 bytes) is formed in one pass and loaded into a
// result buffer, which shifts out one byte per cycle while the output is not stalled.
// An item yields as many result bytes as its run holds (one for a plain ASCII byte, up
// to sixteen), and an item with no result, such as a held UTF-8 lead, leaves the buffer
// empty. The single output byte lane sets the rate; the next item is loaded while the
// last byte of the previous run is taken, so plain text flows at one byte per cycle
// while the output does not stall.
module json_string_escape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] byte_in,
	input  logic       first_of_string,
	input  logic       last_of_string,
	input  logic       empty_string,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_end,
	output logic       string_end
);

	// Input register.
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic        empty_s1;

	// Result buffer.
	logic [127:0] res_s2;
	logic [4:0]   cnt_s2;
	logic         close_s2;

	// Held UTF-8 sequence.
	logic [7:0]  held_lead_q;
	logic [7:0]  held_cont_q [2];
	logic [1:0]  held_count_q;

	// Working signals of the single pass.
	logic         advance;
	logic [1:0]   hc_eff;
	logic         ok;
	logic [2:0]   need;
	jse_pkg::fresh_t fr;
	logic [71:0]  pre_seg;
	logic [3:0]   pre_len;
	logic [47:0]  main_seg;
	logic [2:0]   main_len;
	logic [1:0]   hc_feed;
	logic         cont_wr;
	logic         cont_idx;
	logic         lead_wr;
	logic [71:0]  post_seg;
	logic [3:0]   post_len;
	logic [4:0]   pos;
	logic [127:0] acc;
	logic [1:0]   hc_next;

	// Load the next run while the buffer is empty or its last byte is taken.
	assign advance  = v_s1 && ((cnt_s2 == 5'd0) || ((cnt_s2 == 5'd1) && !out_stall));
	assign in_stall = v_s1 && !advance;

	// Output side of the result buffer.
	assign out_valid  = (cnt_s2 != 5'd0);
	assign out_byte   = res_s2[7:0];
	assign run_end    = (cnt_s2 == 5'd1);
	assign string_end = (cnt_s2 == 5'd1) && close_s2;

	// Classify the byte against the held sequence.
	always_comb begin
		hc_eff = first_s1 ? 2'd0 : held_count_q;
		ok     = jse_pkg::cont_ok(hc_eff, held_lead_q, byte_s1);
		need   = jse_pkg::seq_len(held_lead_q);
		fr     = jse_pkg::fresh(byte_s1);
		cont_idx = 1'(hc_eff - 2'd1);

		pre_seg  = '0;
		pre_len  = 4'd0;
		main_seg = '0;
		main_len = 3'd0;
		hc_feed  = 2'd0;
		cont_wr  = 1'b0;
		lead_wr  = 1'b0;

		if (hc_eff == 2'd0 || !ok) begin
			// A broken sequence is flushed, then the byte starts afresh.
			if (hc_eff != 2'd0) begin
				pre_seg = jse_pkg::repl_run(hc_eff);
				pre_len = jse_pkg::repl_len(hc_eff);
			end
			main_seg = fr.seg;
			main_len = fr.len;
			if (fr.hold) begin
				hc_feed = 2'd1;
				lead_wr = 1'b1;
			end
		end else if (({1'b0, hc_eff} + 3'd1) >= need) begin
			// The sequence is complete and passes through.
			case (hc_eff)
				2'd1:    main_seg = {32'h0, byte_s1, held_lead_q};
				2'd2:    main_seg = {24'h0, byte_s1, held_cont_q[0], held_lead_q};
				default: main_seg = {16'h0, byte_s1, held_cont_q[1], held_cont_q[0],
					held_lead_q};
			endcase
			main_len = {1'b0, hc_eff} + 3'd1;
		end else begin
			// Another continuation byte is held.
			hc_feed = hc_eff + 2'd1;
			cont_wr = 1'b1;
		end

		// A string that ends flushes what is still held.
		post_seg = '0;
		post_len = 4'd0;
		if (last_s1) begin
			post_seg = jse_pkg::repl_run(hc_feed);
			post_len = jse_pkg::repl_len(hc_feed);
		end
	end

	// Pack the segments of the run, first byte in the low position.
	always_comb begin
		acc = '0;
		pos = 5'd0;
		hc_next = hc_feed;
		if (empty_s1) begin
			acc = {112'h0, jse_pkg::QUOTE, jse_pkg::QUOTE};
			pos = 5'd2;
			hc_next = 2'd0;
		end else begin
			if (first_s1) begin
				acc = {120'h0, jse_pkg::QUOTE};
				pos = 5'd1;
			end
			acc = acc | ({56'h0, pre_seg} << {pos, 3'b000});
			pos = pos + {1'b0, pre_len};
			acc = acc | ({80'h0, main_seg} << {pos, 3'b000});
			pos = pos + {2'b00, main_len};
			if (last_s1) begin
				acc = acc | ({56'h0, post_seg} << {pos, 3'b000});
				pos = pos + {1'b0, post_len};
				acc = acc | ({120'h0, jse_pkg::QUOTE} << {pos, 3'b000});
				pos = pos + 5'd1;
				hc_next = 2'd0;
			end
		end
	end

	// Input register control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (!in_stall) begin
			v_s1 <= in_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1  <= byte_in;
			first_s1 <= first_of_string;
			last_s1  <= last_of_string;
			empty_s1 <= empty_string;
		end
	end

	// Result buffer count and held sequence state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_s2       <= 5'd0;
			held_count_q <= 2'd0;
			held_lead_q  <= 8'h00;
		end else if (advance) begin
			cnt_s2       <= pos;
			held_count_q <= hc_next;
			if (lead_wr && !empty_s1) held_lead_q <= byte_s1;
		end else if (out_valid && !out_stall) begin
			cnt_s2 <= cnt_s2 - 5'd1;
		end
	end

	// Result buffer bytes shift toward the output.
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= acc;
			close_s2 <= last_s1 || empty_s1;
		end else if (out_valid && !out_stall) begin
			res_s2 <= {8'h00, res_s2[127:8]};
		end
	end

	// Continuation bytes of a sequence in progress.
	always_ff @(posedge clk) begin
		if (advance && cont_wr && !empty_s1) begin
			held_cont_q[cont_idx] <= byte_s1;
		end
	end

`ifndef ASSERT_OFF
	// The result buffer never holds more than one worst-case run.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_s2 <= 5'd16)
		else $error("result count exceeds sixteen");

	// A held sequence is always shorter than its lead announces.
	a_held_len: assert property (@(posedge clk) disable iff (!arst_n)
		(held_count_q != 2'd0) |-> (jse_pkg::seq_len(held_lead_q) > {1'b0, held_count_q}))
		else $error("held sequence is not shorter than its lead length");

	// The closing quote ends its run.
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && string_end) |-> (run_end && out_byte == jse_pkg::QUOTE))
		else $error("closing quote is not the last byte of its run");

	// A loaded item with an empty buffer is never held back.
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && cnt_s2 == 5'd0) |-> !in_stall)
		else $error("input stalled while the result buffer is empty");

	// A taken last byte with an item waiting leads to the next run at once.
	a_refill: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid && run_end && !out_stall) |=> !$past(in_stall))
		else $error("input stalled across a run boundary");
`endif

endmodule
